// File: rtl/srhsf_pkg.sv
// ----------------------------------------------------------------------------
// srhsf_pkg
// Shared constants and codes for the source routing header forward unit.
// ----------------------------------------------------------------------------
package srhsf_pkg;

   // Buffer sizing
   localparam int MAX_HEADER_BYTES = 256;
   localparam int DST_BYTES        = 16;
   localparam int FIXED_BYTES      = 8;

   // Width of header offsets and length arithmetic (covers 8 + 8 * 255 + 16)
   localparam int OFF_W = 12;

   // Configuration register indexes
   localparam logic [2:0] CSR_OWN_A_HIGH = 3'd0;
   localparam logic [2:0] CSR_OWN_A_LOW  = 3'd1;
   localparam logic [2:0] CSR_OWN_B_HIGH = 3'd2;
   localparam logic [2:0] CSR_OWN_B_LOW  = 3'd3;
   localparam logic [2:0] CSR_OWN_VALID  = 3'd4;

   // Result status codes
   localparam logic [2:0] ST_FORWARD   = 3'd0;
   localparam logic [2:0] ST_BAD_LEN   = 3'd1;
   localparam logic [2:0] ST_SEG_EXC   = 3'd2;
   localparam logic [2:0] ST_MC_DST    = 3'd3;
   localparam logic [2:0] ST_MC_NEXT   = 3'd4;
   localparam logic [2:0] ST_MULTI_OWN = 3'd5;
   localparam logic [2:0] ST_ZERO_SEG  = 3'd6;
   localparam logic [2:0] ST_OVERFLOW  = 3'd7;

   localparam logic [63:0] LL_PREFIX_HIGH = 64'hFE80_0000_0000_0000;
   localparam logic [7:0]  MCAST_BYTE     = 8'hFF;

endpackage

// File: rtl/srh_segment_forward_unit.sv
// ----------------------------------------------------------------------------
// srh_segment_forward_unit
// Source routing header forwarding step: buffers destination and header,
// then checks the header, picks the next hop and forms the buffer patch.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle while the unit is idle; the buffer write
// port sets that rate. After the last byte the unit stalls input while
// it finds the next hop and scans the vector for own addresses (one
// buffer read port, each byte via S_RD and S_CAP), then offers one word.
// Synchronous reset clears byte count, overflow flag, result valid, config
// and state; the packet buffer is not cleared and needs no clearing pass.
module srh_segment_forward_unit #(
   parameter int MAX_HEADER_BYTES = srhsf_pkg::MAX_HEADER_BYTES
) (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata,
   // byte stream
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   // result
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic        rsp_error_valid,
   output logic [7:0]  rsp_error_offset,
   output logic [63:0] rsp_next_dst_high,
   output logic [63:0] rsp_next_dst_low,
   output logic [7:0]  rsp_segments_after,
   output logic [7:0]  rsp_patch_offset,
   output logic [4:0]  rsp_patch_length,
   output logic [63:0] rsp_patch_high,
   output logic [63:0] rsp_patch_low
);

   localparam int OW        = srhsf_pkg::OFF_W;
   localparam int BUF_DEPTH = srhsf_pkg::DST_BYTES + MAX_HEADER_BYTES;
   localparam int AW        = $clog2(BUF_DEPTH);
   localparam int CW        = $clog2(BUF_DEPTH + 1);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_CHECK = 4'd1;
   localparam logic [3:0] S_DIVW  = 4'd2;
   localparam logic [3:0] S_POST  = 4'd3;
   localparam logic [3:0] S_RD    = 4'd4;
   localparam logic [3:0] S_CAP   = 4'd5;
   localparam logic [3:0] S_HOP   = 4'd6;
   localparam logic [3:0] S_CMP   = 4'd7;
   localparam logic [3:0] S_FIN   = 4'd8;

   // configuration registers
   logic [63:0] own_a_high_ff, own_a_low_ff, own_b_high_ff, own_b_low_ff;
   logic [1:0]  own_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_a_high_ff <= '0;
         own_a_low_ff  <= '0;
         own_b_high_ff <= '0;
         own_b_low_ff  <= '0;
         own_valid_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            srhsf_pkg::CSR_OWN_A_HIGH: own_a_high_ff <= csr_wdata;
            srhsf_pkg::CSR_OWN_A_LOW:  own_a_low_ff  <= csr_wdata;
            srhsf_pkg::CSR_OWN_B_HIGH: own_b_high_ff <= csr_wdata;
            srhsf_pkg::CSR_OWN_B_LOW:  own_b_low_ff  <= csr_wdata;
            srhsf_pkg::CSR_OWN_VALID:  own_valid_ff  <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   // state
   logic [3:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic          ovf_ff, ovf_in;
   logic [127:0]  dst_ff, dst_in;
   logic [7:0]    hlen_ff, hlen_in, segl_ff, segl_in, cie_ff, cie_in, pad_ff, pad_in;
   logic [OW-1:0] n_ff, n_in, voff_ff, voff_in, off_ff, off_in, i_ff, i_in;
   logic [OW-1:0] fpos_ff, fpos_in;
   logic          found_ff, found_in, phase_ff, phase_in, rd_ok_ff, rd_ok_in;
   logic [7:0]    nsl_ff, nsl_in;
   logic [3:0]    pref_ff, pref_in, p_ff, p_in, k_ff, k_in;
   logic [127:0]  cand_ff, cand_in, hop_ff, hop_in;
   logic [2:0]    res_st_ff, res_st_in;
   logic          res_ev_ff, res_ev_in;
   logic [7:0]    res_eoff_ff, res_eoff_in;

   // result word
   logic          rsp_valid_ff, rsp_valid_in;
   logic [2:0]    status_ff, status_in;
   logic          ev_ff, ev_in;
   logic [7:0]    eoff_ff, eoff_in;
   logic [63:0]   ndh_ff, ndh_in, ndl_ff, ndl_in, ph_ff, ph_in, pl_ff, pl_in;
   logic [7:0]    sa_ff, sa_in, po_ff, po_in;
   logic [4:0]    plen_ff, plen_in;

   // packet buffer
   logic [7:0]    mem [BUF_DEPTH];
   logic [7:0]    mem_q;
   logic [AW-1:0] rd_addr;
   logic          acc, wr_en;

   // divider
   logic          div_start, div_done;
   logic [OW-1:0] div_dividend, quotient;
   logic [4:0]    clen;

   srhsf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (clen),
      .done     (div_done),
      .quotient (quotient)
   );

   // header fields
   logic [3:0]    ci, ce, pad;
   logic [OW-1:0] len8, cnt_ext, min_len, n_calc, pos, prod, idx;
   logic          is_own;
   logic [127:0]  patch;

   assign acc     = req_valid && !req_stall;
   assign wr_en   = acc && (count_ff < CW'(BUF_DEPTH));
   assign ci      = cie_ff[7:4];
   assign ce      = cie_ff[3:0];
   assign pad     = pad_ff[7:4];
   assign clen    = 5'(5'd16 - {1'b0, ci});
   assign len8    = OW'({hlen_ff, 3'b000});
   assign cnt_ext = OW'(count_ff);
   assign min_len = OW'(pad) + OW'(16) - OW'(ce);
   assign div_dividend = len8 - min_len;
   assign n_calc  = quotient + OW'(1);
   assign pos     = n_ff - OW'(nsl_ff);
   assign prod    = OW'((pos - OW'(1)) * OW'(clen));
   assign idx     = OW'(16) + voff_ff + OW'(k_ff) - OW'(p_ff);
   assign rd_addr = idx[AW-1:0];
   assign is_own  = (own_valid_ff[0] && cand_ff == {own_a_high_ff, own_a_low_ff}) ||
                    (own_valid_ff[1] && cand_ff == {own_b_high_ff, own_b_low_ff});
   assign patch   = dst_ff << {pref_ff, 3'b000};

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[AW-1:0]] <= req_data_byte;
      end
      mem_q <= mem[rd_addr];
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      ovf_in      = ovf_ff;
      dst_in      = dst_ff;
      hlen_in     = hlen_ff;
      segl_in     = segl_ff;
      cie_in      = cie_ff;
      pad_in      = pad_ff;
      n_in        = n_ff;
      voff_in     = voff_ff;
      off_in      = off_ff;
      i_in        = i_ff;
      fpos_in     = fpos_ff;
      found_in    = found_ff;
      phase_in    = phase_ff;
      rd_ok_in    = rd_ok_ff;
      nsl_in      = nsl_ff;
      pref_in     = pref_ff;
      p_in        = p_ff;
      k_in        = k_ff;
      cand_in     = cand_ff;
      hop_in      = hop_ff;
      res_st_in   = res_st_ff;
      res_ev_in   = res_ev_ff;
      res_eoff_in = res_eoff_ff;
      div_start   = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      status_in   = status_ff;
      ev_in       = ev_ff;
      eoff_in     = eoff_ff;
      ndh_in      = ndh_ff;
      ndl_in      = ndl_ff;
      sa_in       = sa_ff;
      po_in       = po_ff;
      plen_in     = plen_ff;
      ph_in       = ph_ff;
      pl_in       = pl_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (acc) begin
               if (wr_en) begin
                  count_in = count_ff + 1'b1;
                  if (count_ff < CW'(16)) begin
                     dst_in[{~count_ff[3:0], 3'b000} +: 8] = req_data_byte;
                  end
                  if (count_ff == CW'(17)) hlen_in = req_data_byte;
                  if (count_ff == CW'(19)) segl_in = req_data_byte;
                  if (count_ff == CW'(20)) cie_in  = req_data_byte;
                  if (count_ff == CW'(21)) pad_in  = req_data_byte;
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_last_byte) state_in = S_CHECK;
            end
         end
         // length and segment checks on captured fields
         S_CHECK: begin
            res_ev_in   = 1'b0;
            res_eoff_in = 8'd0;
            state_in    = S_FIN;
            priority if (ovf_ff || count_ff < CW'(24)) begin
               res_st_in = srhsf_pkg::ST_OVERFLOW;
            end else if (OW'(8) + len8 > cnt_ext - OW'(16)) begin
               res_st_in = srhsf_pkg::ST_OVERFLOW;
            end else if (len8 < min_len) begin
               res_st_in = srhsf_pkg::ST_BAD_LEN;
               res_ev_in = 1'b1;
               res_eoff_in = 8'd1;
            end else if (segl_ff == 8'd0) begin
               res_st_in = srhsf_pkg::ST_ZERO_SEG;
               res_ev_in = 1'b1;
               res_eoff_in = 8'd3;
            end else begin
               div_start = 1'b1;
               state_in  = S_DIVW;
            end
         end
         S_DIVW: begin
            if (div_done) begin
               n_in     = n_calc;
               nsl_in   = segl_ff - 8'd1;
               state_in = S_POST;
               if (OW'(segl_ff) > n_calc) begin
                  res_st_in   = srhsf_pkg::ST_SEG_EXC;
                  res_ev_in   = 1'b1;
                  res_eoff_in = 8'd3;
                  state_in    = S_FIN;
               end
            end
         end
         // next hop position, then build it
         S_POST: begin
            pref_in  = (nsl_ff != 8'd0) ? ci : ce;
            p_in     = (nsl_ff != 8'd0) ? ci : ce;
            k_in     = (nsl_ff != 8'd0) ? ci : ce;
            off_in   = OW'(8) + prod;
            voff_in  = OW'(8) + prod;
            cand_in  = dst_ff;
            phase_in = 1'b0;
            state_in = S_RD;
         end
         S_RD: begin
            rd_ok_in = idx < cnt_ext;
            state_in = S_CAP;
         end
         S_CAP: begin
            cand_in[{~k_ff, 3'b000} +: 8] = rd_ok_ff ? mem_q : 8'd0;
            if (k_ff == 4'd15) begin
               state_in = phase_ff ? S_CMP : S_HOP;
            end else begin
               k_in     = k_ff + 4'd1;
               state_in = S_RD;
            end
         end
         // multicast checks, then start own-address scan at entry 0
         S_HOP: begin
            hop_in   = cand_ff;
            res_ev_in   = 1'b0;
            res_eoff_in = 8'd0;
            priority if (dst_ff[127:120] == srhsf_pkg::MCAST_BYTE) begin
               res_st_in = srhsf_pkg::ST_MC_DST;
               state_in  = S_FIN;
            end else if (cand_ff[127:120] == srhsf_pkg::MCAST_BYTE) begin
               res_st_in = srhsf_pkg::ST_MC_NEXT;
               state_in  = S_FIN;
            end else begin
               res_st_in = srhsf_pkg::ST_FORWARD;
               i_in      = '0;
               fpos_in   = '0;
               found_in  = 1'b0;
               phase_in  = 1'b1;
               voff_in   = OW'(8);
               p_in      = (n_ff == OW'(1)) ? ce : ci;
               k_in      = (n_ff == OW'(1)) ? ce : ci;
               cand_in   = dst_ff;
               state_in  = S_RD;
            end
         end
         S_CMP: begin
            if (is_own && found_ff && (i_ff - fpos_ff) > OW'(1)) begin
               res_st_in   = srhsf_pkg::ST_MULTI_OWN;
               res_ev_in   = 1'b1;
               res_eoff_in = voff_ff[7:0];
               state_in    = S_FIN;
            end else begin
               if (is_own) begin
                  fpos_in  = i_ff;
                  found_in = 1'b1;
               end
               i_in = i_ff + OW'(1);
               if (i_ff + OW'(1) == n_ff) begin
                  state_in = S_FIN;
               end else begin
                  voff_in  = voff_ff + OW'(clen);
                  p_in     = (i_ff + OW'(2) == n_ff) ? ce : ci;
                  k_in     = (i_ff + OW'(2) == n_ff) ? ce : ci;
                  cand_in  = dst_ff;
                  state_in = S_RD;
               end
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               status_in    = res_st_ff;
               ev_in        = res_ev_ff;
               eoff_in      = res_eoff_ff;
               if (res_st_ff == srhsf_pkg::ST_FORWARD) begin
                  ndh_in  = srhsf_pkg::LL_PREFIX_HIGH;
                  ndl_in  = hop_ff[63:0];
                  sa_in   = nsl_ff;
                  po_in   = off_ff[7:0];
                  plen_in = 5'(5'd16 - {1'b0, pref_ff});
                  ph_in   = patch[127:64];
                  pl_in   = patch[63:0];
               end else begin
                  ndh_in  = '0;
                  ndl_in  = '0;
                  sa_in   = '0;
                  po_in   = '0;
                  plen_in = '0;
                  ph_in   = '0;
                  pl_in   = '0;
               end
               count_in = '0;
               ovf_in   = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dst_ff      <= dst_in;
      hlen_ff     <= hlen_in;
      segl_ff     <= segl_in;
      cie_ff      <= cie_in;
      pad_ff      <= pad_in;
      n_ff        <= n_in;
      voff_ff     <= voff_in;
      off_ff      <= off_in;
      i_ff        <= i_in;
      fpos_ff     <= fpos_in;
      found_ff    <= found_in;
      phase_ff    <= phase_in;
      rd_ok_ff    <= rd_ok_in;
      nsl_ff      <= nsl_in;
      pref_ff     <= pref_in;
      p_ff        <= p_in;
      k_ff        <= k_in;
      cand_ff     <= cand_in;
      hop_ff      <= hop_in;
      res_st_ff   <= res_st_in;
      res_ev_ff   <= res_ev_in;
      res_eoff_ff <= res_eoff_in;
      status_ff   <= status_in;
      ev_ff       <= ev_in;
      eoff_ff     <= eoff_in;
      ndh_ff      <= ndh_in;
      ndl_ff      <= ndl_in;
      sa_ff       <= sa_in;
      po_ff       <= po_in;
      plen_ff     <= plen_in;
      ph_ff       <= ph_in;
      pl_ff       <= pl_in;
   end

   assign req_stall          = (state_ff != S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_error_valid    = ev_ff;
   assign rsp_error_offset   = eoff_ff;
   assign rsp_next_dst_high  = ndh_ff;
   assign rsp_next_dst_low   = ndl_ff;
   assign rsp_segments_after = sa_ff;
   assign rsp_patch_offset   = po_ff;
   assign rsp_patch_length   = plen_ff;
   assign rsp_patch_high     = ph_ff;
   assign rsp_patch_low      = pl_ff;

   // byte count never passes the buffer depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(BUF_DEPTH))
      else $error("byte count beyond buffer depth");

   // a new result word only comes out of the final state
   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_FIN)
      else $error("result raised outside final state");

   // a buffer read never precedes the first vector byte of the entry
   a_read_in_entry: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RD |-> k_ff >= p_ff)
      else $error("read index below entry prefix");

endmodule

// File: rtl/srhsf_div.sv
// ----------------------------------------------------------------------------
// srhsf_div
// Restoring divider, one quotient bit per cycle, divisor 1..16.
// ----------------------------------------------------------------------------
module srhsf_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [srhsf_pkg::OFF_W-1:0] dividend,
   input  logic [4:0]                  divisor,
   output logic                        done,
   output logic [srhsf_pkg::OFF_W-1:0] quotient
);

   localparam int OW = srhsf_pkg::OFF_W;
   localparam int CNT_W = $clog2(OW + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [OW-1:0] quo_ff, quo_in;
   logic [4:0]    rem_ff, rem_in;
   logic [4:0]    dvs_ff, dvs_in;
   logic [5:0]    trial;
   logic          ge;

   // one trial subtraction per cycle
   always_comb begin
      trial   = {rem_ff, quo_ff[OW-1]};
      ge      = trial >= {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(OW);
         quo_in  = dividend;
         rem_in  = 5'd0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? 5'(trial - {1'b0, dvs_ff}) : trial[4:0];
         quo_in = {quo_ff[OW-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
